FILE: hdl/boxsat_pkg.sv
package boxsat_pkg;

  localparam int ENTRY_BITS = 21;
  localparam int REG_BITS   = 63;
  localparam int NUM_REGS   = 4;
  localparam int NUM_AXES   = 15;
  localparam int AXC_BITS   = ENTRY_BITS + 1;
  localparam int MAG_BITS   = 2 * ENTRY_BITS;
  localparam int HSUM_BITS  = ENTRY_BITS + 2;
  localparam int PROD_BITS  = AXC_BITS + ENTRY_BITS;

  typedef enum logic [1:0] {
    REG_AXIS_X      = 2'd0,
    REG_AXIS_Y      = 2'd1,
    REG_AXIS_Z      = 2'd2,
    REG_TRANSLATION = 2'd3
  } reg_idx_t;

  typedef logic signed [AXC_BITS-1:0] axc_t;
  typedef logic [MAG_BITS-1:0]        mag_t;
  typedef logic [HSUM_BITS-1:0]       hsum_t;

  // Per-configuration values shared by every box test
  typedef struct {
    axc_t  axis [NUM_AXES][3];
    hsum_t hsum [NUM_AXES];
    mag_t  dmag [NUM_AXES][3];
  } derived_t;

  function automatic logic signed [ENTRY_BITS-1:0] entry_of(
    input logic [REG_BITS-1:0] r,
    input int                  comp
  );
    return r[ENTRY_BITS*comp +: ENTRY_BITS];
  endfunction

endpackage

FILE: hdl/boxsat_if.sv
interface boxsat_in_if #(parameter int COORD_BITS = 24);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] min_z;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] max_y;
  logic signed [COORD_BITS-1:0] max_z;
  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface boxsat_out_if;
  logic valid;
  logic ready;
  logic overlaps;
  modport source (output valid, overlaps, input ready);
  modport sink (input valid, overlaps, output ready);
endinterface

FILE: hdl/boxsat_axes.sv
module boxsat_axes #(
  parameter int FRAC_BITS = 12
) (
  input  logic                                                clk,
  input  logic [boxsat_pkg::NUM_REGS-1:0][boxsat_pkg::REG_BITS-1:0] regs,
  output boxsat_pkg::derived_t                                derived
);
  import boxsat_pkg::*;

  localparam int SUMW = PROD_BITS + 2;

  axc_t                          ax       [NUM_AXES][3];
  logic signed [PROD_BITS-1:0]   prod_nxt [NUM_AXES][3][3];
  logic signed [PROD_BITS-1:0]   prod_r   [NUM_AXES][3][3];
  hsum_t                         hsum_nxt [NUM_AXES];
  hsum_t                         hsum_r   [NUM_AXES];
  axc_t                          axis_r   [NUM_AXES][3];
  mag_t                          dmag_nxt [NUM_AXES][3];
  mag_t                          dmag_r   [NUM_AXES][3];

  // Candidate axes: region axes, matrix columns, region axis cross column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ax[k][i] = (i == k) ? (axc_t'(1) <<< FRAC_BITS) : '0;
      end
    end
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        ax[3+j][i] = axc_t'(entry_of(regs[j], i));
      end
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (k == 0) begin
          ax[6+3*k+j][0] = '0;
          ax[6+3*k+j][1] = -axc_t'(entry_of(regs[j], 2));
          ax[6+3*k+j][2] = axc_t'(entry_of(regs[j], 1));
        end else if (k == 1) begin
          ax[6+3*k+j][0] = axc_t'(entry_of(regs[j], 2));
          ax[6+3*k+j][1] = '0;
          ax[6+3*k+j][2] = -axc_t'(entry_of(regs[j], 0));
        end else begin
          ax[6+3*k+j][0] = -axc_t'(entry_of(regs[j], 1));
          ax[6+3*k+j][1] = axc_t'(entry_of(regs[j], 0));
          ax[6+3*k+j][2] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      hsum_nxt[n] = (HSUM_BITS'(ax[n][0] < 0 ? -ax[n][0] : ax[n][0]) << 1)
                  + (HSUM_BITS'(ax[n][1] < 0 ? -ax[n][1] : ax[n][1]) << 1)
                  + HSUM_BITS'(ax[n][2] < 0 ? -ax[n][2] : ax[n][2]);
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          prod_nxt[n][j][i] = PROD_BITS'(ax[n][i]) * PROD_BITS'(entry_of(regs[j], i));
        end
      end
    end
  end

  // Magnitude of each axis projected on each column
  always_comb begin
    logic signed [SUMW-1:0] s;
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int j = 0; j < 3; j++) begin
        s = SUMW'(prod_r[n][j][0]) + SUMW'(prod_r[n][j][1]) + SUMW'(prod_r[n][j][2]);
        dmag_nxt[n][j] = MAG_BITS'(s < 0 ? -s : s);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    hsum_r <= hsum_nxt;
    axis_r <= ax;
    dmag_r <= dmag_nxt;
  end

  assign derived.axis = axis_r;
  assign derived.hsum = hsum_r;
  assign derived.dmag = dmag_r;

endmodule

FILE: hdl/box_overlap_separating_axis.sv
// Separating-axis culling test of an axis-aligned box against the local region
// [-1,1] x [-1,1] x [0,1]. Write the three matrix columns and the translation
// over the APB port (64-bit data, register i at byte address 8*i, each holding
// three signed 21-bit entries packed x, y, z from bit 0). After a write the
// input holds ready low while the per-matrix axis terms settle. One box word is
// taken every cycle while ready is high and its overlaps word leaves through the
// output register; a stall on the output holds the whole pipeline. An inverted
// box (min above max on any axis) reports no overlap.
module box_overlap_separating_axis #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 12
) (
  input  logic         clk,
  input  logic         rst_n,
  boxsat_in_if.sink    in_ch,
  boxsat_out_if.source out_ch,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import boxsat_pkg::*;

  localparam int EB   = ENTRY_BITS;
  localparam int CW   = COORD_BITS + 1;
  localparam int AW   = AXC_BITS;
  localparam int MW   = MAG_BITS;
  localparam int HLO  = MW / 2;
  localparam int HHI  = MW - HLO;
  localparam int PCW  = EB + CW;
  localparam int TW   = EB + FRAC_BITS + 1;
  localparam int DW   = ((PCW > TW) ? PCW : TW) + 3;
  localparam int DL   = DW / 2;
  localparam int DHW  = DW - DL;
  localparam int QLW  = AW + DL + 1;
  localparam int QHW  = AW + DHW;
  localparam int PW   = AW + DW;
  localparam int SW   = PW + 2;
  localparam int RTW  = MW + CW;

  // ---------------- configuration registers ----------------
  logic [NUM_REGS-1:0][REG_BITS-1:0] cfg_r;
  logic [1:0]                        busy_r, busy_nxt;
  logic                              cfg_wr;
  derived_t                          derived;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = {1'b0, cfg_r[paddr[4:3]]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      cfg_r[paddr[4:3]] <= pwdata[REG_BITS-1:0];
    end
  end

  // Hold off input while the derived axis terms catch up with a write
  always_comb begin
    busy_nxt = busy_r;
    if (cfg_wr) begin
      busy_nxt = 2'd2;
    end else if (busy_r != 2'd0) begin
      busy_nxt = busy_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  boxsat_axes #(.FRAC_BITS(FRAC_BITS)) u_axes (
    .clk     (clk),
    .regs    (cfg_r),
    .derived (derived)
  );

  // ---------------- pipeline control ----------------
  logic [7:1] vld_r, vld_nxt;
  logic [6:1] emp_r, emp_nxt;
  logic       en, in_acc, empty;

  // Advance everything whenever the output register is free or being taken
  assign en           = !vld_r[7] || out_ch.ready;
  assign in_ch.ready  = en && (busy_r == 2'd0);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign vld_nxt      = {vld_r[6:1], in_acc};
  assign emp_nxt      = {emp_r[5:1], empty};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      emp_r <= emp_nxt;
    end
  end

  // ---------------- stage 1: centre and width (both doubled) ----------------
  logic signed [COORD_BITS-1:0] lo [3];
  logic signed [COORD_BITS-1:0] hi [3];
  logic signed [CW-1:0]         c1_nxt [3], c1_r [3];
  logic [CW-1:0]                w1_nxt [3], w1_r [3];

  assign lo[0] = in_ch.min_x;
  assign lo[1] = in_ch.min_y;
  assign lo[2] = in_ch.min_z;
  assign hi[0] = in_ch.max_x;
  assign hi[1] = in_ch.max_y;
  assign hi[2] = in_ch.max_z;

  always_comb begin
    empty = 1'b0;
    for (int i = 0; i < 3; i++) begin
      c1_nxt[i] = CW'(lo[i]) + CW'(hi[i]);
      w1_nxt[i] = CW'(hi[i]) - CW'(lo[i]);
      if (lo[i] > hi[i]) begin
        empty = 1'b1;
      end
    end
  end

  // ---------------- stage 2: matrix products, radius partial products ----------
  logic signed [PCW-1:0] pc2_nxt [3][3], pc2_r [3][3];
  logic [HLO+CW-1:0]     ml2_nxt [NUM_AXES][3], ml2_r [NUM_AXES][3];
  logic [HHI+CW-1:0]     mh2_nxt [NUM_AXES][3], mh2_r [NUM_AXES][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pc2_nxt[i][j] = PCW'(entry_of(cfg_r[j], i)) * PCW'(c1_r[j]);
      end
    end
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int j = 0; j < 3; j++) begin
        ml2_nxt[n][j] = (HLO+CW)'(derived.dmag[n][j][HLO-1:0]) * (HLO+CW)'(w1_r[j]);
        mh2_nxt[n][j] = (HHI+CW)'(derived.dmag[n][j][MW-1:HLO]) * (HHI+CW)'(w1_r[j]);
      end
    end
  end

  // ---------------- stage 3: centre gap, radius terms ----------------
  logic signed [DW-1:0] d3_nxt [3], d3_r [3];
  logic [RTW-1:0]       rt3_nxt [NUM_AXES][3], rt3_r [NUM_AXES][3];

  always_comb begin
    logic signed [DW-1:0] base;
    for (int i = 0; i < 3; i++) begin
      base = (i == 2) ? (DW'(1) <<< (2*FRAC_BITS)) : '0;
      d3_nxt[i] = base - ((DW'(entry_of(cfg_r[REG_TRANSLATION], i)) <<< (FRAC_BITS+1))
                          + DW'(pc2_r[i][0]) + DW'(pc2_r[i][1]) + DW'(pc2_r[i][2]));
    end
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int j = 0; j < 3; j++) begin
        rt3_nxt[n][j] = (RTW'(mh2_r[n][j]) << HLO) + RTW'(ml2_r[n][j]);
      end
    end
  end

  // ---------------- stage 4: split gap products, full radius ----------------
  logic signed [QLW-1:0] ql4_nxt [NUM_AXES][3], ql4_r [NUM_AXES][3];
  logic signed [QHW-1:0] qh4_nxt [NUM_AXES][3], qh4_r [NUM_AXES][3];
  logic [SW-1:0]         rad4_nxt [NUM_AXES], rad4_r [NUM_AXES];

  always_comb begin
    logic signed [QLW-1:0] dlo;
    logic signed [QHW-1:0] dhi;
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int i = 0; i < 3; i++) begin
        dlo = QLW'({1'b0, d3_r[i][DL-1:0]});
        dhi = QHW'($signed(d3_r[i][DW-1:DL]));
        ql4_nxt[n][i] = QLW'(derived.axis[n][i]) * dlo;
        qh4_nxt[n][i] = QHW'(derived.axis[n][i]) * dhi;
      end
      rad4_nxt[n] = (SW'(derived.hsum[n]) << (2*FRAC_BITS))
                  + SW'(rt3_r[n][0]) + SW'(rt3_r[n][1]) + SW'(rt3_r[n][2]);
    end
  end

  // ---------------- stage 5: recombine gap products ----------------
  logic signed [PW-1:0] pr5_nxt [NUM_AXES][3], pr5_r [NUM_AXES][3];
  logic [SW-1:0]        rad5_r [NUM_AXES];

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      for (int i = 0; i < 3; i++) begin
        pr5_nxt[n][i] = (PW'(qh4_r[n][i]) <<< DL) + PW'(ql4_r[n][i]);
      end
    end
  end

  // ---------------- stage 6: projection, both radius bounds ----------------
  logic signed [SW-1:0] p6_nxt [NUM_AXES], p6_r [NUM_AXES];
  logic signed [SW-1:0] prad6_nxt [NUM_AXES], prad6_r [NUM_AXES];
  logic signed [SW-1:0] nrad6_nxt [NUM_AXES], nrad6_r [NUM_AXES];

  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      p6_nxt[n]    = SW'(pr5_r[n][0]) + SW'(pr5_r[n][1]) + SW'(pr5_r[n][2]);
      prad6_nxt[n] = $signed(rad5_r[n]);
      nrad6_nxt[n] = -$signed(rad5_r[n]);
    end
  end

  // ---------------- stage 7: separation decision (output register) ----------
  logic                ov7_nxt, ov7_r;
  logic [NUM_AXES-1:0] sep;

  // Drop overlap if any axis projects the gap beyond the summed radii
  always_comb begin
    for (int n = 0; n < NUM_AXES; n++) begin
      sep[n] = (p6_r[n] > prad6_r[n]) || (p6_r[n] < nrad6_r[n]);
    end
    ov7_nxt = !emp_r[6] && (sep == '0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r    <= c1_nxt;
      w1_r    <= w1_nxt;
      pc2_r   <= pc2_nxt;
      ml2_r   <= ml2_nxt;
      mh2_r   <= mh2_nxt;
      d3_r    <= d3_nxt;
      rt3_r   <= rt3_nxt;
      ql4_r   <= ql4_nxt;
      qh4_r   <= qh4_nxt;
      rad4_r  <= rad4_nxt;
      pr5_r   <= pr5_nxt;
      rad5_r  <= rad4_r;
      p6_r    <= p6_nxt;
      prad6_r <= prad6_nxt;
      nrad6_r <= nrad6_nxt;
      ov7_r   <= ov7_nxt;
    end
  end

  assign out_ch.valid    = vld_r[7];
  assign out_ch.overlaps = ov7_r;

  // ---------------- checks ----------------
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> !in_acc ##1 !in_acc)
    else $error("box word taken before derived axis terms settled");

  a_empty_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (en && vld_r[6] && emp_r[6]) |=> (vld_r[7] && !ov7_r))
    else $error("inverted box reported as overlapping");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vld_r) && $stable(ov7_r)))
    else $error("pipeline moved during output stall");

endmodule

FILE: sim/tb_box_overlap_separating_axis.sv
module tb_box_overlap_separating_axis;
  import boxsat_pkg::*;

  localparam int CB = 24;
  localparam int FB = 12;
  localparam int PIPE_LAT = 10;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_BOXES = 1250;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  boxsat_in_if #(.COORD_BITS(CB)) in_ch ();
  boxsat_out_if out_ch ();

  box_overlap_separating_axis #(.COORD_BITS(CB), .FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic signed [CB-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  } box_t;

  // One row of the directed table: box, and an expectation where it is obvious
  typedef struct {
    box_t box;
    bit   known;
    bit   overlaps;
  } row_t;

  // Local copy of the matrix registers
  logic [REG_BITS-1:0] mat_reg [NUM_REGS];

  bit   overlap_q [$];
  int   mismatches;
  int   words_out;
  int   idle_cycles;
  bit   no_idle;
  bit   timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sign-extend one packed 21-bit matrix entry
  function automatic longint entry_val(int r, int comp);
    logic signed [ENTRY_BITS-1:0] e;
    e = mat_reg[r][ENTRY_BITS*comp +: ENTRY_BITS];
    return longint'(e);
  endfunction

  function automatic logic [127:0] abs128(logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Exact separating-axis test of one box against the region
  function automatic bit predict_overlap(box_t b);
    longint lo [3], hi [3], c [3], w [3], d [3], col [3][3], ax [15][3], s, dp;
    logic signed [127:0] proj;
    logic [127:0] rad;
    longint h2 [3];
    h2[0] = 2; h2[1] = 2; h2[2] = 1;
    lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
    hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
    for (int i = 0; i < 3; i++) begin
      if (lo[i] > hi[i]) return 1'b0;
      c[i] = lo[i] + hi[i];
      w[i] = hi[i] - lo[i];
    end
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) col[j][i] = entry_val(j, i);
    for (int i = 0; i < 3; i++) begin
      s = entry_val(REG_TRANSLATION, i) * (longint'(1) << (FB + 1));
      for (int j = 0; j < 3; j++) s += col[j][i] * c[j];
      d[i] = (i == 2 ? (longint'(1) << (2 * FB)) : 0) - s;
    end
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < 3; i++) ax[k][i] = (i == k) ? (longint'(1) << FB) : 0;
    for (int j = 0; j < 3; j++)
      for (int i = 0; i < 3; i++) ax[3 + j][i] = col[j][i];
    for (int k = 0; k < 3; k++)
      for (int j = 0; j < 3; j++) begin
        case (k)
          0: begin ax[6+3*k+j][0] = 0; ax[6+3*k+j][1] = -col[j][2];
            ax[6+3*k+j][2] = col[j][1]; end
          1: begin ax[6+3*k+j][0] = col[j][2]; ax[6+3*k+j][1] = 0;
            ax[6+3*k+j][2] = -col[j][0]; end
          default: begin ax[6+3*k+j][0] = -col[j][1];
            ax[6+3*k+j][1] = col[j][0]; ax[6+3*k+j][2] = 0; end
        endcase
      end
    for (int k = 0; k < 15; k++) begin
      proj = 0;
      rad = 0;
      for (int i = 0; i < 3; i++) begin
        proj += 128'(signed'(d[i])) * 128'(signed'(ax[k][i]));
        rad += abs128(128'(signed'(ax[k][i]))) * (128'(h2[i]) << (2 * FB));
      end
      for (int j = 0; j < 3; j++) begin
        dp = 0;
        for (int i = 0; i < 3; i++) dp += ax[k][i] * col[j][i];
        rad += abs128(128'(signed'(dp))) * 128'(w[j]);
      end
      if (abs128(proj) > rad) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Setup then access phase; the register takes the word at the access edge
  task automatic write_reg(logic [63:0] idx, logic [63:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx * 8); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx < NUM_REGS) mat_reg[idx] = value[REG_BITS-1:0];
    @(posedge clk);
  endtask

  function automatic logic [20:0] q812(int v);
    return 21'(v);
  endfunction

  function automatic logic [63:0] pack3(int x, int y, int z);
    return {1'b0, q812(z), q812(y), q812(x)};
  endfunction

  // Drain the pipeline before touching the matrix
  task automatic settle();
    while (overlap_q.size() != 0 && !timed_out) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic send_box(box_t b, bit known, bit exp_val);
    int gap;
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.min_x, in_ch.min_y, in_ch.min_z, in_ch.max_x, in_ch.max_y, in_ch.max_z} <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // Directed rows with a typed-in value are still cross-checked by the predictor
    if (known && exp_val != predict_overlap(b))
      $display("directed row disagrees with predictor, expected %0b", exp_val);
    overlap_q.push_back(known ? exp_val : predict_overlap(b));
  endtask

  // Random box: mostly ordered corners of modest size, some inverted or extreme
  function automatic box_t rand_box();
    box_t b;
    int sel;
    logic signed [CB-1:0] a, z;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (sel == 0) begin
        a = CB'($urandom); z = CB'($urandom);
      end else begin
        a = CB'($signed($urandom_range(0, 24000)) - 12000);
        z = a + CB'($urandom_range(0, (sel < 3) ? 8000000 : 6000));
        if (z < a) z = a;
      end
      case (i)
        0: begin b.min_x = a; b.max_x = z; end
        1: begin b.min_y = a; b.max_y = z; end
        default: begin b.min_z = a; b.max_z = z; end
      endcase
    end
    return b;
  endfunction

  function automatic int rand_entry(bit wide);
    if (wide) return $signed($urandom_range(0, 2097151)) - 1048576;
    return $signed($urandom_range(0, 16384)) - 8192;
  endfunction

  task automatic rand_matrix();
    bit wide;
    wide = ($urandom_range(0, 4) == 0);
    for (int r = 0; r < NUM_REGS; r++) begin
      if (wide || r == REG_TRANSLATION)
        write_reg(r, {$urandom, $urandom});
      else
        write_reg(r, pack3(rand_entry(0), rand_entry(0), rand_entry(0)));
    end
    if (!wide) write_reg(REG_TRANSLATION,
        pack3(rand_entry(0) / 8, rand_entry(0) / 8, rand_entry(0) / 4));
  endtask

  // Sink side: random back-pressure bursts, compare each word with the oldest prediction
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (!no_idle && $urandom_range(0, 6) == 0) begin
        stall = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (overlap_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: overlaps=%0b", out_ch.overlaps);
        end else begin
          bit e;
          e = overlap_q.pop_front();
          if (out_ch.overlaps !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("overlaps mismatch: expected %0b, got %0b", e, out_ch.overlaps);
          end
        end
      end
    end
  end

  // Watchdog: count cycles where no word moves on either channel and no register access is under way
  initial begin
    timed_out = 1'b0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else if (++idle_cycles >= WATCHDOG_LIMIT) begin
        timed_out = 1'b1;
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    row_t rows [$];
    localparam logic signed [CB-1:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [CB-1:0] CMIN = -24'sh800000;
    localparam int ONE = 1 << FB;

    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.min_x, in_ch.min_y, in_ch.min_z, in_ch.max_x, in_ch.max_y, in_ch.max_z} = '0;
    mismatches = 0; words_out = 0; no_idle = 1'b0;
    for (int r = 0; r < NUM_REGS; r++) mat_reg[r] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the matrix is zero: every box maps to the origin, which lies in the region
    rows.push_back('{box: '{0, 0, 0, 0, 0, 0}, known: 1, overlaps: 1});
    rows.push_back('{box: '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, known: 1, overlaps: 1});
    // Inverted boxes on each axis report no overlap
    rows.push_back('{box: '{1, 0, 0, 0, 0, 0}, known: 1, overlaps: 0});
    rows.push_back('{box: '{0, CMAX, 0, 0, CMIN, 0}, known: 1, overlaps: 0});
    rows.push_back('{box: '{0, 0, 5, 0, 0, 4}, known: 1, overlaps: 0});
    foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].overlaps);
    in_ch.valid <= 1'b0;
    settle();

    // Identity matrix, no translation; also set the ignored top bit of a word
    write_reg(REG_AXIS_X, pack3(ONE, 0, 0));
    write_reg(REG_AXIS_Y, pack3(0, ONE, 0));
    write_reg(REG_AXIS_Z, pack3(0, 0, ONE));
    write_reg(REG_TRANSLATION, 64'h8000_0000_0000_0000);
    rows.delete();
    rows.push_back('{box: '{0, 0, 0, 0, 0, ONE/2}, known: 0, overlaps: 0});
    rows.push_back('{box: '{5*ONE, 5*ONE, 5*ONE, 6*ONE, 6*ONE, 6*ONE}, known: 0, overlaps: 0});
    rows.push_back('{box: '{-ONE, -ONE, -2*ONE, -ONE, -ONE, 0}, known: 0, overlaps: 0});
    rows.push_back('{box: '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, known: 0, overlaps: 0});
    rows.push_back('{box: '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX}, known: 0, overlaps: 0});
    rows.push_back('{box: '{CMIN, CMIN, CMIN, CMIN, CMIN, CMIN}, known: 0, overlaps: 0});
    rows.push_back('{box: '{ONE, 0, 0, ONE+1, 1, 1}, known: 0, overlaps: 0});
    foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].overlaps);
    in_ch.valid <= 1'b0;
    settle();

    // Extreme entries: all-ones and most negative / most positive columns
    write_reg(REG_AXIS_X, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_AXIS_Y, {1'b0, 21'h100000, 21'h100000, 21'h100000});
    write_reg(REG_AXIS_Z, {1'b0, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    write_reg(REG_TRANSLATION, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0});
    rows.delete();
    rows.push_back('{box: '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}, known: 0, overlaps: 0});
    rows.push_back('{box: '{0, 0, 0, 0, 0, 0}, known: 0, overlaps: 0});
    rows.push_back('{box: '{CMAX, CMIN, 0, CMAX, CMIN, 0}, known: 0, overlaps: 0});
    foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].overlaps);
    in_ch.valid <= 1'b0;
    settle();

    // Degenerate columns so some cross-product axes are all zero
    write_reg(REG_AXIS_X, pack3(0, 0, 0));
    write_reg(REG_AXIS_Y, pack3(0, 0, ONE));
    write_reg(REG_AXIS_Z, pack3(ONE/2, 0, 0));
    write_reg(REG_TRANSLATION, pack3(0, 0, ONE/4));
    rows.delete();
    rows.push_back('{box: '{-ONE, -ONE, -ONE, ONE, ONE, ONE}, known: 0, overlaps: 0});
    rows.push_back('{box: '{9*ONE, 0, 9*ONE, 9*ONE, 0, 9*ONE}, known: 0, overlaps: 0});
    foreach (rows[i]) send_box(rows[i].box, rows[i].known, rows[i].overlaps);

    // Hold the sender until every expected word has come
    in_ch.valid <= 1'b0;
    while (overlap_q.size() != 0) @(posedge clk);
    settle();

    // Random phases, each under a fresh matrix; the last two phases run without idling
    for (int n = 0; n < RANDOM_BOXES; n++) begin
      if (n % 125 == 0) begin
        in_ch.valid <= 1'b0;
        settle();
        if (n >= RANDOM_BOXES - 250) no_idle = 1'b1;
        rand_matrix();
      end
      send_box(rand_box(), 0, 0);
    end
    in_ch.valid <= 1'b0;

    while (overlap_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    if (mismatches == 0 && overlap_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
